@@ design/adc_channel_average_filter_unit_macros.svh @@
// Assertion macros for the ADC channel average filter.
// No dependencies; included by the top level only.
`ifndef ADC_CHANNEL_AVERAGE_FILTER_UNIT_MACROS_SVH
`define ADC_CHANNEL_AVERAGE_FILTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ACFU_ASSERT_IMPL(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("acfu: implication check failed");
`define ACFU_ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("acfu: next-cycle check failed");
`else
`define ACFU_ASSERT_IMPL(lbl, a, b)
`define ACFU_ASSERT_NEXT(lbl, a, b)
`endif
`endif

@@ design/acfu_pkg.sv @@
// Shared types and constants of the ADC channel average filter.
// No dependencies.
package acfu_pkg;

	localparam int CH_W    = 4;
	localparam int TOTAL_W = 18;
	localparam int POS_W   = 7;
	localparam int BLK_MAX = 40;
	localparam int LEN_W   = 6;

	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;
	localparam logic [1:0] CFG_BLKSEL = 2'd2;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic meta_eval;
		logic old_eval;
		logic load_step;
		logic sort_step;
		logic wb_step;
		logic div_start;
		logic div_finish;
		logic res_load;
	} acfu_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic in_oor;
		logic blk_mode;
		logic blk_complete;
		logic load_done;
		logic sort_done;
		logic wb_done;
		logic div_done;
		logic out_free;
	} acfu_sts_t;

	function automatic logic [LEN_W-1:0] blk_len(input logic [1:0] sel);
		logic [LEN_W-1:0] r;
		case (sel)
			2'd0:    r = 6'd10;
			2'd1:    r = 6'd20;
			2'd2:    r = 6'd30;
			default: r = 6'd40;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] blk_half(input logic [1:0] sel);
		logic [LEN_W-1:0] r;
		case (sel)
			2'd0:    r = 6'd5;
			2'd1:    r = 6'd10;
			2'd2:    r = 6'd15;
			default: r = 6'd20;
		endcase
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] blk_offset(input logic [1:0] sel);
		logic [LEN_W-1:0] r;
		case (sel)
			2'd0:    r = 6'd3;
			2'd1:    r = 6'd5;
			2'd2:    r = 6'd7;
			default: r = 6'd9;
		endcase
		return r;
	endfunction

endpackage

@@ design/acfu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acfu_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/acfu_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
module acfu_div #(
	parameter int DVD_W = 18,
	parameter int DVS_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ design/acfu_ctrl.sv @@
// Controller state machine of the ADC channel average filter.
// Depends on acfu_pkg.
module acfu_ctrl import acfu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  acfu_sts_t sts,
	output acfu_cmd_t cmd,
	output logic      s_tready
);
	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_META  = 9'b000000100,
		ST_OLD   = 9'b000001000,
		ST_LOAD  = 9'b000010000,
		ST_SORT  = 9'b000100000,
		ST_WB    = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_RES   = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = sts.in_oor ? ST_RES : ST_META;
				end
			end
			ST_META: begin
				cmd.meta_eval = 1'b1;
				if (!sts.blk_mode) state_d = ST_OLD;
				else if (sts.blk_complete) state_d = ST_LOAD;
				else state_d = ST_RES;
			end
			ST_OLD: begin
				cmd.old_eval  = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_LOAD: begin
				cmd.load_step = 1'b1;
				if (sts.load_done) state_d = ST_SORT;
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_done) state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb_step = 1'b1;
				if (sts.wb_done) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.div_finish = 1'b1;
					state_d        = ST_RES;
				end
			end
			ST_RES: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
endmodule

@@ design/acfu_dp.sv @@
// Datapath: sample store, per-channel total/position store, sorter, divider
// and output register. Depends on acfu_pkg, acfu_ram and acfu_div.
module acfu_dp import acfu_pkg::*; #(
	parameter int CHANNELS    = 16,
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  acfu_cmd_t              cmd,
	output acfu_sts_t              sts,
	input  logic [CH_W-1:0]        in_ch,
	input  logic [SAMPLE_BITS-1:0] in_val,
	input  logic                   filter_mode,
	input  logic [POS_W-1:0]       run_window,
	input  logic [1:0]             block_size_sel,
	input  logic                   m_tready,
	output logic                   out_valid,
	output logic [CH_W-1:0]        out_ch,
	output logic [SAMPLE_BITS-1:0] out_avg,
	output logic                   out_done
);
	localparam int ST_DEPTH = CHANNELS * MAX_WINDOW;
	localparam int ST_AW    = $clog2(ST_DEPTH);
	localparam int CH_AW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int META_W   = TOTAL_W + POS_W;
	localparam int SUM_W    = SAMPLE_BITS + 5;
	localparam int DVD_W    = SUM_W > TOTAL_W ? SUM_W : TOTAL_W;
	localparam int AVG_MAX  = (1 << SAMPLE_BITS) - 1;

	// item registers
	logic [CH_W-1:0]        ch_q;
	logic [CH_AW-1:0]       ch_idx_q;
	logic [SAMPLE_BITS-1:0] val_q;
	logic [ST_AW-1:0]       base_q;
	logic [POS_W-1:0]       pos_q;
	logic [TOTAL_W-1:0]     total_q;
	logic [SAMPLE_BITS-1:0] res_avg_q;
	logic                   res_done_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SAMPLE_BITS-1:0] srt_q [BLK_MAX];
	logic [SAMPLE_BITS-1:0] srt_d [BLK_MAX];
	// control registers
	logic [ST_AW-1:0]       clr_q;
	logic [LEN_W-1:0]       cnt_q;
	logic [LEN_W-1:0]       pass_q;
	logic                   out_valid_q;
	logic [CH_W-1:0]        out_ch_q;
	logic [SAMPLE_BITS-1:0] out_avg_q;
	logic                   out_done_q;

	logic                   st_we, meta_we;
	logic [ST_AW-1:0]       st_waddr, st_raddr;
	logic [SAMPLE_BITS-1:0] st_wdata, st_rdata;
	logic [CH_AW-1:0]       meta_waddr, in_idx;
	logic [META_W-1:0]      meta_wdata, meta_rdata;

	logic [POS_W-1:0]       w_eff, lim, pos_a, pos_n, meta_pos;
	logic [TOTAL_W-1:0]     meta_tot, new_tot;
	logic [LEN_W-1:0]       n_len, half, offs;
	logic                   complete, in_sum;
	logic [SUM_W-1:0]       sum_nxt;
	logic [DVD_W-1:0]       dividend, quo;
	logic [POS_W-1:0]       divisor;
	logic [TOTAL_W-1:0]     blk_tot;
	logic                   div_done;

	assign in_idx   = CH_AW'(in_ch);
	assign n_len    = blk_len(block_size_sel);
	assign half     = blk_half(block_size_sel);
	assign offs     = blk_offset(block_size_sel);
	assign meta_tot = meta_rdata[META_W-1:POS_W];
	assign meta_pos = meta_rdata[POS_W-1:0];

	always_comb begin
		if (run_window == '0) w_eff = POS_W'(1);
		else if (int'(run_window) > MAX_WINDOW) w_eff = POS_W'(MAX_WINDOW);
		else w_eff = run_window;
	end

	assign lim      = filter_mode ? POS_W'(n_len) : w_eff;
	assign pos_a    = (meta_pos >= lim) ? '0 : meta_pos;
	assign pos_n    = pos_a + 1'b1;
	assign complete = (pos_n == POS_W'(n_len));
	assign new_tot  = total_q - TOTAL_W'(st_rdata) + TOTAL_W'(val_q);
	assign in_sum   = (cnt_q >= offs) && (cnt_q < offs + half);
	assign sum_nxt  = sum_q + (in_sum ? SUM_W'(srt_q[0]) : '0);
	assign dividend = filter_mode ? DVD_W'(sum_nxt) : DVD_W'(new_tot);
	assign divisor  = filter_mode ? POS_W'(half) : w_eff;
	assign blk_tot  = quo[TOTAL_W-1:0];

	// sample store write / read port selection
	always_comb begin
		st_we    = 1'b0;
		st_waddr = base_q + ST_AW'(pos_a);
		st_wdata = val_q;
		if (cmd.clr_step) begin
			st_we    = 1'b1;
			st_waddr = clr_q;
			st_wdata = '0;
		end else if (cmd.meta_eval && filter_mode) begin
			st_we = 1'b1;
		end else if (cmd.old_eval) begin
			st_we    = 1'b1;
			st_waddr = base_q + ST_AW'(pos_q);
		end else if (cmd.wb_step) begin
			st_we    = 1'b1;
			st_waddr = base_q + ST_AW'(cnt_q);
			st_wdata = srt_q[0];
		end
	end
	assign st_raddr = cmd.load_step ? base_q + ST_AW'(cnt_q) : base_q + ST_AW'(pos_a);

	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = ch_idx_q;
		meta_wdata = {meta_tot, pos_n};
		if (cmd.clr_step) begin
			meta_we    = int'(clr_q) < CHANNELS;
			meta_waddr = clr_q[CH_AW-1:0];
			meta_wdata = '0;
		end else if (cmd.meta_eval && filter_mode) begin
			meta_we = !complete;
		end else if (cmd.old_eval) begin
			meta_we    = 1'b1;
			meta_wdata = {new_tot, pos_q + 1'b1};
		end else if (cmd.div_finish && filter_mode) begin
			meta_we    = 1'b1;
			meta_wdata = {blk_tot, {POS_W{1'b0}}};
		end
	end

	acfu_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(ST_DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	acfu_ram #(.WIDTH(META_W), .DEPTH(CHANNELS)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (in_idx),
		.rdata (meta_rdata)
	);

	acfu_div #(.DVD_W(DVD_W), .DVS_W(POS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// one odd-even transposition pass
	always_comb begin
		int j;
		for (int i = 0; i < BLK_MAX; i++) srt_d[i] = srt_q[i];
		for (int i = 0; i < BLK_MAX / 2; i++) begin
			j = 2 * i + int'(pass_q[0]);
			if (j + 1 < BLK_MAX && srt_q[j] > srt_q[j+1]) begin
				srt_d[j]   = srt_q[j+1];
				srt_d[j+1] = srt_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			cnt_q       <= '0;
			pass_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
			if (cmd.meta_eval) cnt_q <= '0;
			if (cmd.load_step) cnt_q <= sts.load_done ? '0 : cnt_q + 1'b1;
			if (cmd.wb_step) cnt_q <= cnt_q + 1'b1;
			if (cmd.load_step) pass_q <= '0;
			if (cmd.sort_step) pass_q <= pass_q + 1'b1;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q       <= in_ch;
			ch_idx_q   <= in_idx;
			val_q      <= in_val;
			base_q     <= ST_AW'(in_idx * MAX_WINDOW);
			res_avg_q  <= '0;
			res_done_q <= 1'b0;
		end
		if (cmd.meta_eval) begin
			pos_q   <= pos_a;
			total_q <= meta_tot;
			sum_q   <= '0;
			if (filter_mode && !complete) begin
				res_avg_q  <= (meta_tot > TOTAL_W'(AVG_MAX)) ? SAMPLE_BITS'(AVG_MAX)
					: meta_tot[SAMPLE_BITS-1:0];
				res_done_q <= 1'b0;
			end
			for (int i = 0; i < BLK_MAX; i++) srt_q[i] <= '1;
		end
		if (cmd.load_step && cnt_q != '0) begin
			srt_q[0] <= st_rdata;
			for (int i = 1; i < BLK_MAX; i++) srt_q[i] <= srt_q[i-1];
		end
		if (cmd.sort_step) begin
			for (int i = 0; i < BLK_MAX; i++) srt_q[i] <= srt_d[i];
		end
		if (cmd.wb_step) begin
			sum_q <= sum_nxt;
			for (int i = 0; i < BLK_MAX - 1; i++) srt_q[i] <= srt_q[i+1];
			srt_q[BLK_MAX-1] <= '1;
		end
		if (cmd.div_finish) begin
			if (filter_mode) begin
				res_avg_q  <= (blk_tot > TOTAL_W'(AVG_MAX)) ? SAMPLE_BITS'(AVG_MAX)
					: blk_tot[SAMPLE_BITS-1:0];
				res_done_q <= 1'b1;
			end else begin
				res_avg_q  <= (quo > DVD_W'(AVG_MAX)) ? SAMPLE_BITS'(AVG_MAX)
					: quo[SAMPLE_BITS-1:0];
				res_done_q <= 1'b0;
			end
		end
		if (cmd.res_load) begin
			out_ch_q   <= ch_q;
			out_avg_q  <= res_avg_q;
			out_done_q <= res_done_q;
		end
	end

	always_comb begin
		sts              = '0;
		sts.clear_done   = (clr_q == ST_AW'(ST_DEPTH - 1));
		sts.in_oor       = int'(in_ch) >= CHANNELS;
		sts.blk_mode     = filter_mode;
		sts.blk_complete = complete;
		sts.load_done    = (cnt_q == n_len);
		sts.sort_done    = (pass_q == LEN_W'(BLK_MAX - 1));
		sts.wb_done      = (cnt_q == n_len - 1'b1);
		sts.div_done     = div_done;
		sts.out_free     = !out_valid_q || m_tready;
	end

	assign out_valid = out_valid_q;
	assign out_ch    = out_ch_q;
	assign out_avg   = out_avg_q;
	assign out_done  = out_done_q;
endmodule

@@ design/adc_channel_average_filter_unit.sv @@
// ADC channel average filter, top level: stream ports, configuration
// registers, controller and datapath. Depends on acfu_pkg, acfu_ctrl, acfu_dp.
//
// Usage
//  - s_* stream: one transfer per sample, tdata = {sample, channel}.
//  - m_* stream: one transfer per sample, tdata = {average, channel},
//    tuser = block_done.
//  - cfg_*: register writes (0 filter_mode, 1 run_window, 2 block_size_sel),
//    always ready; write only while no sample is in flight.
//  - After reset the sample store is swept to zero, one word a cycle,
//    CHANNELS*MAX_WINDOW words (1024 at defaults); s_tready stays low.
//  - One sample is worked on at a time. Path from acceptance to the load of
//    the output register: out-of-range channel direct; block mode, block not
//    complete via the metadata state; running mode via metadata, old-sample
//    and the one-bit-per-cycle divider; completing block via load through the
//    store port, the 40-pass sorter, write-back and the divider. The next
//    sample is taken in the cycle after that load at best.
//  - The result sits in an output register; the next sample is taken while
//    it waits. If m_tready stays low the following result is held back and
//    s_tready drops until the register frees.
`include "adc_channel_average_filter_unit_macros.svh"
module adc_channel_average_filter_unit import acfu_pkg::*; #(
	parameter int CHANNELS    = 16,
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	// tdata: channel, sample
	input  logic [((CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: out_channel, average
	output logic [((CH_W + SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// tuser: block_done
	output logic [0:0] m_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int TW = ((CH_W + SAMPLE_BITS + 7) / 8) * 8;

	logic                   mode_q;
	logic [POS_W-1:0]       win_q;
	logic [1:0]             sel_q;
	acfu_cmd_t              cmd;
	acfu_sts_t              sts;
	logic [CH_W-1:0]        out_ch;
	logic [SAMPLE_BITS-1:0] out_avg;
	logic                   out_done;

	assign cfg_ready = 1'b1;

	// configuration registers, a write needs no settling time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			win_q  <= POS_W'(16);
			sel_q  <= 2'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q <= cfg_data[0];
				CFG_WINDOW: win_q  <= cfg_data[POS_W-1:0];
				CFG_BLKSEL: sel_q  <= cfg_data[1:0];
				default:    ;
			endcase
		end
	end

	acfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	acfu_dp #(
		.CHANNELS    (CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_ch          (s_tdata[CH_W-1:0]),
		.in_val         (s_tdata[CH_W +: SAMPLE_BITS]),
		.filter_mode    (mode_q),
		.run_window     (win_q),
		.block_size_sel (sel_q),
		.m_tready       (m_tready),
		.out_valid      (m_tvalid),
		.out_ch         (out_ch),
		.out_avg        (out_avg),
		.out_done       (out_done)
	);

	assign m_tdata    = TW'({out_avg, out_ch});
	assign m_tuser[0] = out_done;

	// one sample in flight at a time
	`ACFU_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
	// result only moved into a free output register
	`ACFU_ASSERT_IMPL(a_res_free, cmd.res_load, sts.out_free)
	// a completed block only in block mode
	`ACFU_ASSERT_IMPL(a_done_blk, m_tvalid && m_tuser[0], mode_q)
endmodule

@@ sim/tb_adc_channel_average_filter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the ADC channel average filter: directed table, then random
// sample streams over several register settings, checked against a behavioural filter model.
// Depends on acfu_pkg and the adc_channel_average_filter_unit RTL.
module tb_adc_channel_average_filter_unit;
	import acfu_pkg::*;

	localparam int NCH  = 16;
	localparam int MAXW = 64;
	localparam int DW   = 16;
	localparam int LIMIT = 3000000;

	typedef struct packed {
		logic [3:0]  chan;
		logic [11:0] avg;
		logic        done;
	} filt_res_t;

	// directed row: sample in, optional typed-in expectation
	typedef struct {
		logic [3:0]  chan;
		logic [11:0] smp;
		bit          known;
		filt_res_t   res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [DW-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_MODE;
	logic [7:0] cfg_data = '0;

	// model state
	logic [11:0] smp_store [NCH][MAXW];
	logic [17:0] win_total [NCH];
	logic [6:0]  wr_pos [NCH];
	logic        mode_q;
	logic [6:0]  window_q;
	logic [1:0]  blksel_q;

	filt_res_t pending_avgs[$];
	int   cycle_cnt = 0;
	bit   failed = 0;
	int   rx_stall_pat;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	adc_channel_average_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic filt_res_t filter_sample(input logic [3:0] ch, input logic [11:0] v);
		filt_res_t r;
		int w, p, n, half, offs, sum;
		logic [11:0] blk [40];
		logic [11:0] key;
		int j;
		r.chan = ch;
		r.avg  = '0;
		r.done = 1'b0;
		p = wr_pos[ch];
		if (mode_q == 1'b0) begin
			w = window_q;
			if (w == 0) w = 1;
			if (w > MAXW) w = MAXW;
			if (p >= w) p = 0;
			win_total[ch] = win_total[ch] - 18'(smp_store[ch][p]);
			smp_store[ch][p] = v;
			win_total[ch] = win_total[ch] + 18'(v);
			wr_pos[ch] = 7'(p + 1);
			r.avg = (win_total[ch] / w > 4095) ? 12'd4095 : 12'(win_total[ch] / w);
		end else begin
			n = 10 * (blksel_q + 1);
			half = n / 2;
			offs = 2 * blksel_q + 3;
			if (p >= n) p = 0;
			smp_store[ch][p] = v;
			p++;
			if (p == n) begin
				// insertion sort in place, as the store holds the sorted block afterwards
				for (int i = 0; i < n; i++) blk[i] = smp_store[ch][i];
				for (int i = 1; i < n; i++) begin
					key = blk[i];
					j = i;
					while (j > 0 && blk[j-1] > key) begin
						blk[j] = blk[j-1];
						j--;
					end
					blk[j] = key;
				end
				for (int i = 0; i < n; i++) smp_store[ch][i] = blk[i];
				sum = 0;
				for (int i = 0; i < half; i++) sum += blk[offs + i];
				win_total[ch] = 18'(sum / half);
				p = 0;
				r.done = 1'b1;
			end
			wr_pos[ch] = 7'(p);
			r.avg = (win_total[ch] > 4095) ? 12'd4095 : win_total[ch][11:0];
		end
		return r;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		// idle: all results in, then let the slowest possible pass drain
		wait (pending_avgs.size() == 0);
		repeat (200) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MODE:   mode_q   = val[0];
			CFG_WINDOW: window_q = val[6:0];
			CFG_BLKSEL: blksel_q = val[1:0];
			default: ;
		endcase
	endtask

	// one transfer on the sample stream; prediction queued at acceptance
	task automatic send_sample(input logic [3:0] ch, input logic [11:0] v,
			input bit known, input filt_res_t res);
		filt_res_t p;
		s_tvalid <= 1'b1;
		s_tdata  <= {v, ch};
		do @(posedge clk); while (!s_tready);
		p = filter_sample(ch, v);
		if (known && p !== res) begin
			$error("directed row ch %0d: average exp %0d got %0d, block_done exp %0d got %0d",
				ch, res.avg, p.avg, res.done, p.done);
			failed = 1;
		end
		pending_avgs.push_back(p);
	endtask

	task automatic sender_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic random_phase(input int cnt, input int chan_hi);
		int burst;
		burst = 0;
		for (int i = 0; i < cnt; i++) begin
			if (burst == 0) begin
				sender_gap();
				burst = $urandom_range(1, 20);
			end
			burst--;
			// mostly a few channels so blocks fill; extremes of the sample now and then
			case ($urandom_range(0, 5))
				0: send_sample(4'($urandom_range(0, chan_hi)), 12'hFFF, 0, '0);
				1: send_sample(4'($urandom_range(0, chan_hi)), 12'h000, 0, '0);
				default: send_sample(4'($urandom_range(0, chan_hi)), 12'($urandom), 0, '0);
			endcase
		end
		s_tvalid <= 1'b0;
	endtask

	// receiver: stalls on a rolling pattern, with stretches always ready
	always @(posedge clk) begin
		rx_stall_pat <= (rx_stall_pat == 0) ? $urandom : rx_stall_pat >> 1;
		if (cycle_cnt[11:10] == 2'd0) m_tready <= 1'b1;
		else m_tready <= rx_stall_pat[0] | rx_stall_pat[1];
	end

	// result checker
	always @(posedge clk) begin
		filt_res_t e;
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_avgs.size() == 0) begin
				$error("unexpected result on channel %0d", m_tdata[3:0]);
				failed = 1;
			end else begin
				e = pending_avgs.pop_front();
				if (m_tdata[3:0] !== e.chan) begin
					$error("out_channel exp %0d got %0d", e.chan, m_tdata[3:0]);
					failed = 1;
				end
				if (m_tdata[15:4] !== e.avg) begin
					$error("average exp %0d got %0d", e.avg, m_tdata[15:4]);
					failed = 1;
				end
				if (m_tuser[0] !== e.done) begin
					$error("block_done exp %0d got %0d", e.done, m_tuser[0]);
					failed = 1;
				end
			end
		end
		if (cycle_cnt >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	initial begin
		dir_row_t row;
		for (int c = 0; c < NCH; c++) begin
			win_total[c] = '0;
			wr_pos[c] = '0;
			for (int k = 0; k < MAXW; k++) smp_store[c][k] = '0;
		end
		mode_q = 1'b0;
		window_q = 7'd16;
		blksel_q = 2'd1;
		rx_stall_pat = 0;

		// after reset, window 16: full-scale sample gives 4095/16
		row = '{4'd0, 12'hFFF, 1, '{4'd0, 12'd255, 1'b0}};  dir_rows.push_back(row);
		row = '{4'd15, 12'hFFF, 1, '{4'd15, 12'd255, 1'b0}}; dir_rows.push_back(row);
		row = '{4'd15, 12'h000, 1, '{4'd15, 12'd255, 1'b0}}; dir_rows.push_back(row);
		row = '{4'd5, 12'h001, 1, '{4'd5, 12'd0, 1'b0}};     dir_rows.push_back(row);
		row = '{4'd5, 12'hAAA, 0, '0};                      dir_rows.push_back(row);
		row = '{4'd10, 12'h555, 0, '0};                     dir_rows.push_back(row);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) send_sample(dir_rows[i].chan, dir_rows[i].smp,
			dir_rows[i].known, dir_rows[i].res);
		s_tvalid <= 1'b0;

		// window zero behaves as one, above-max saturates, then extremes
		write_reg(CFG_WINDOW, 8'd0);
		send_sample(4'd3, 12'hFFF, 1, '{4'd3, 12'd4095, 1'b0});
		s_tvalid <= 1'b0;
		write_reg(CFG_WINDOW, 8'd127);
		random_phase(100, 3);
		write_reg(CFG_WINDOW, 8'd1);
		random_phase(60, 15);
		write_reg(CFG_WINDOW, 8'd64);
		random_phase(150, 2);

		// block mode over every size; positions carry over from running mode
		for (int s = 0; s < 4; s++) begin
			write_reg(CFG_MODE, 8'd1);
			write_reg(CFG_BLKSEL, 8'(s));
			random_phase(220, 1 + s);
		end
		write_reg(CFG_BLKSEL, 8'd0);
		random_phase(120, 15);

		// back to running with stale totals, then mixed
		write_reg(CFG_MODE, 8'd0);
		write_reg(CFG_WINDOW, 8'd7);
		random_phase(100, 7);
		write_reg(CFG_WINDOW, 8'd40);
		random_phase(100, 15);
		write_reg(CFG_MODE, 8'd1);
		write_reg(CFG_BLKSEL, 8'd3);
		random_phase(140, 0);

		wait (pending_avgs.size() == 0);
		repeat (300) @(posedge clk);
		if (!failed) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ adc_channel_average_filter_unit.f @@
+incdir+design
design/acfu_pkg.sv
design/acfu_ram.sv
design/acfu_div.sv
design/acfu_ctrl.sv
design/acfu_dp.sv
design/adc_channel_average_filter_unit.sv
sim/tb_adc_channel_average_filter_unit.sv
